// ----- design/cplut_pkg.sv -----
// shared types and constants for the colormap lookup block
`timescale 1ns / 1ps

package cplut_pkg;

    // fixed field widths
    localparam int FIELD_W    = 17;
    localparam int LEVEL_BITS = 16;
    localparam int IDX_IN_W   = 4;
    localparam int NCOL_W     = 5;
    localparam int OUT_W      = 8;
    localparam int SCALE_BITS = 8;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MAP   = 1'b1;

    // channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // one control point as stored in memory
    typedef struct packed {
        logic [FIELD_W-1:0] pos;
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
    } cplut_entry_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_FETCH_R,
        S_CAP_R,
        S_SETUP,
        S_CLASS,
        S_DIVIDE,
        S_MUL,
        S_MIX,
        S_SCALE,
        S_DONE
    } cplut_state_t;

endpackage

// ----- design/cplut_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module cplut_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/colormap_piecewise_linear_lookup.sv -----
// top level: piecewise-linear colormap with control point memory
//
//  channel   signals                            transaction
//  -------   --------------------------------   ------------------------------
//  input     in_valid / in_ready + item fields  write a point or map a sample
//  output    out_valid / out_ready + rgb        one color per map transaction
//  config    cfg_we / cfg_wdata                 num_colors, single cycle write
//
//  write transaction: the memory is written at the accepting edge
//  map transaction: binary search over the points on the single memory read
//  port, reads of the left and right bin points, setup and classification of
//  the fraction, a bit-serial divide only when it lies strictly between zero
//  and one, then multiply, mix and scale for each channel in turn; the three
//  channels share one multiplier
//  reset loads num_colors = 2; the point memory is not cleared
//  a finished color waits in the output register while new items are taken
`timescale 1ns / 1ps

module colormap_piecewise_linear_lookup #(
    parameter int MAX_COLORS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic [cplut_pkg::IDX_IN_W-1:0] point_index,
    input  logic [cplut_pkg::FIELD_W-1:0]  point_position,
    input  logic [cplut_pkg::FIELD_W-1:0]  point_red,
    input  logic [cplut_pkg::FIELD_W-1:0]  point_green,
    input  logic [cplut_pkg::FIELD_W-1:0]  point_blue,
    input  logic [cplut_pkg::FIELD_W-1:0]  sample_value,
    // output channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cplut_pkg::OUT_W-1:0]    red_out,
    output logic [cplut_pkg::OUT_W-1:0]    green_out,
    output logic [cplut_pkg::OUT_W-1:0]    blue_out,
    // configuration
    input  logic                           cfg_we,
    input  logic [cplut_pkg::NCOL_W-1:0]   cfg_wdata
);

    import cplut_pkg::*;

    localparam int IDX_W   = $clog2(MAX_COLORS);
    localparam int CNT_RAW = $clog2(MAX_COLORS + 1);
    localparam int PW      = (CNT_RAW > IDX_IN_W) ? CNT_RAW : IDX_IN_W;
    localparam int CW      = (CNT_RAW > NCOL_W) ? CNT_RAW : NCOL_W;
    localparam int ENTRY_W = $bits(cplut_entry_t);
    localparam int FR_W    = FRAC_BITS + 1;
    localparam int PROD_W  = FIELD_W + 1 + FR_W + 1;
    localparam int MIX_W   = FIELD_W + FRAC_BITS;
    localparam int SCL_W   = MIX_W + SCALE_BITS;
    localparam int DCW     = $clog2(FRAC_BITS);
    localparam int SHIFT   = LEVEL_BITS + FRAC_BITS;

    localparam logic [FR_W-1:0] FRAC_ONE = FR_W'(1) << FRAC_BITS;

    cplut_state_t state_reg, state_next;

    logic [NCOL_W-1:0]  num_colors_reg;
    logic [FIELD_W-1:0] value_reg;
    logic [IDX_W-1:0]   lo_reg;
    logic [IDX_W-1:0]   hi_reg;
    cplut_entry_t       left_reg;
    cplut_entry_t       right_reg;
    logic signed [FIELD_W:0] num_reg;
    logic signed [FIELD_W:0] den_reg;
    logic [FIELD_W-1:0] rem_reg;
    logic [FIELD_W-1:0] dvs_reg;
    logic [DCW-1:0]     div_cnt_reg;
    logic [FR_W-1:0]    frac_reg;
    logic [1:0]         ch_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [MIX_W-1:0]   mix_reg;
    logic [OUT_W-1:0]   chan_res_reg [3];
    logic               out_valid_reg;
    logic [OUT_W-1:0]   red_reg;
    logic [OUT_W-1:0]   green_reg;
    logic [OUT_W-1:0]   blue_reg;

    logic               in_fire;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    cplut_entry_t       rd_entry;
    cplut_entry_t       wr_entry;
    logic [PW-1:0]      idx_wide;
    logic               slot_ok;
    logic [CW-1:0]      n_ext;
    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid;
    logic [IDX_W-1:0]   bin_left;
    logic [IDX_W-1:0]   bin_right;
    logic               div_needed;
    logic signed [FIELD_W:0] den_abs;
    logic signed [FIELD_W:0] num_adj;
    logic [FIELD_W:0]   rem_dbl;
    logic               rem_ge;
    logic [FIELD_W-1:0] lo_lvl;
    logic [FIELD_W-1:0] hi_lvl;
    logic signed [FIELD_W:0]  lvl_diff;
    logic signed [PROD_W-1:0] lo_shift;
    logic signed [PROD_W-1:0] mix_sum;
    logic [SCL_W-1:0]   scaled;
    logic [OUT_W:0]     top_bits;
    logic [OUT_W-1:0]   chan_sat;
    logic               out_load;

    // control point memory: position and levels side by side
    cplut_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_COLORS)
    ) u_points (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_wide[IDX_W-1:0]),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = cplut_entry_t'(ram_rdata);
    assign wr_entry = '{pos: point_position, red: point_red,
                        green: point_green, blue: point_blue};

    // slot range check and active point count
    assign in_fire  = in_valid && in_ready;
    assign idx_wide = PW'(point_index);
    assign slot_ok  = (idx_wide < PW'(MAX_COLORS));
    assign n_ext    = CW'(num_colors_reg);

    always_comb
    begin
        priority if (n_ext < CW'(2))
        begin
            last_idx = IDX_W'(1);
        end
        else if (n_ext > CW'(MAX_COLORS))
        begin
            last_idx = IDX_W'(MAX_COLORS - 1);
        end
        else
        begin
            last_idx = IDX_W'(n_ext - CW'(1));
        end
    end

    // search midpoint and bracketing bin
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[IDX_W:1];
    assign bin_left  = (lo_reg == '0) ? '0 : lo_reg - IDX_W'(1);
    assign bin_right = (lo_reg == '0) ? IDX_W'(1) : lo_reg;

    // fraction classification: orient the bin, pick the trivial cases
    assign den_abs    = (den_reg < 0) ? -den_reg : den_reg;
    assign num_adj    = (den_reg < 0) ? -num_reg : num_reg;
    assign div_needed = (den_reg != 0) && (num_adj > 0) && (num_adj < den_abs);

    // restoring divider step, one quotient bit per cycle
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_ge  = (rem_dbl >= {1'b0, dvs_reg});

    // channel level select
    always_comb
    begin
        unique case (ch_reg)
            CH_RED:
            begin
                lo_lvl = left_reg.red;
                hi_lvl = right_reg.red;
            end
            CH_GREEN:
            begin
                lo_lvl = left_reg.green;
                hi_lvl = right_reg.green;
            end
            CH_BLUE:
            begin
                lo_lvl = left_reg.blue;
                hi_lvl = right_reg.blue;
            end
            default:
            begin
                lo_lvl = left_reg.red;
                hi_lvl = right_reg.red;
            end
        endcase
    end

    // blend as lo*one + (hi - lo)*f, then scale by 255 with shift and subtract
    assign lvl_diff = signed'({1'b0, hi_lvl}) - signed'({1'b0, lo_lvl});
    assign lo_shift = signed'(PROD_W'({lo_lvl, {FRAC_BITS{1'b0}}}));
    assign mix_sum  = lo_shift + prod_reg;
    assign scaled   = {mix_reg, {SCALE_BITS{1'b0}}} - SCL_W'(mix_reg);
    assign top_bits = scaled[SCL_W-1:SHIFT];
    assign chan_sat = top_bits[OUT_W] ? {OUT_W{1'b1}} : top_bits[OUT_W-1:0];

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && operation == OP_MAP)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                state_next = (lo_reg < hi_reg) ? S_COMPARE : S_FETCH_R;
            end
            S_COMPARE: state_next = S_SEARCH;
            S_FETCH_R: state_next = S_CAP_R;
            S_CAP_R:   state_next = S_SETUP;
            S_SETUP:   state_next = S_CLASS;
            S_CLASS:
            begin
                state_next = div_needed ? S_DIVIDE : S_MUL;
            end
            S_DIVIDE:
            begin
                if (div_cnt_reg == DCW'(FRAC_BITS - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_MIX;
            S_MIX: state_next = S_SCALE;
            S_SCALE:
            begin
                state_next = (ch_reg == CH_BLUE) ? S_DONE : S_MUL;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs: handshake and memory ports
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        ram_we    = (state_reg == S_IDLE) && in_valid && (operation == OP_WRITE) && slot_ok;
        ram_raddr = mid;
        unique case (state_reg)
            S_SEARCH:
            begin
                ram_raddr = (lo_reg < hi_reg) ? mid : bin_left;
            end
            S_FETCH_R:
            begin
                ram_raddr = bin_right;
            end
            default:
            begin
                ram_raddr = mid;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_colors_reg <= NCOL_W'(2);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                num_colors_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                value_reg <= sample_value;
                lo_reg    <= '0;
                hi_reg    <= last_idx;
                ch_reg    <= CH_RED;
            end
            S_COMPARE:
            begin
                if (value_reg > rd_entry.pos)
                begin
                    lo_reg <= mid + IDX_W'(1);
                end
                else
                begin
                    hi_reg <= mid;
                end
            end
            S_FETCH_R:
            begin
                left_reg <= rd_entry;
            end
            S_CAP_R:
            begin
                right_reg <= rd_entry;
            end
            S_SETUP:
            begin
                num_reg <= signed'({1'b0, value_reg}) - signed'({1'b0, left_reg.pos});
                den_reg <= signed'({1'b0, right_reg.pos}) - signed'({1'b0, left_reg.pos});
            end
            S_CLASS:
            begin
                rem_reg     <= num_adj[FIELD_W-1:0];
                dvs_reg     <= den_abs[FIELD_W-1:0];
                div_cnt_reg <= '0;
                priority if (div_needed || den_reg == 0 || num_adj <= 0)
                begin
                    frac_reg <= '0;
                end
                else
                begin
                    frac_reg <= FRAC_ONE;
                end
            end
            S_DIVIDE:
            begin
                rem_reg     <= rem_ge ? FIELD_W'(rem_dbl - {1'b0, dvs_reg})
                                      : rem_dbl[FIELD_W-1:0];
                frac_reg    <= {frac_reg[FRAC_BITS-1:0], rem_ge};
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            end
            S_MUL:
            begin
                prod_reg <= PROD_W'(lvl_diff * signed'({1'b0, frac_reg}));
            end
            S_MIX:
            begin
                mix_reg <= mix_sum[MIX_W-1:0];
            end
            S_SCALE:
            begin
                chan_res_reg[ch_reg] <= chan_sat;
                ch_reg               <= ch_reg + 2'd1;
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red_reg   <= chan_res_reg[CH_RED];
            green_reg <= chan_res_reg[CH_GREEN];
            blue_reg  <= chan_res_reg[CH_BLUE];
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

`ifndef SYNTHESIS
    // a write transaction never starts the map sequence
    a_write_no_map: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation == OP_WRITE) |=> (state_reg == S_IDLE))
        else $error("write transaction left idle state");

    // search interval is never empty while a probe is outstanding
    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMPARE) |-> (lo_reg < hi_reg && hi_reg <= $past(hi_reg)))
        else $error("search bounds out of order");

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    // fraction never exceeds one when blending
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (frac_reg <= FRAC_ONE))
        else $error("blend fraction above one");
`endif

endmodule

// ----- dv/tb_colormap_piecewise_linear_lookup.sv -----
// testbench for the piecewise-linear colormap lookup with a self-checking color predictor
`timescale 1ns / 1ps

module tb_colormap_piecewise_linear_lookup;

    import cplut_pkg::*;

    localparam int SLOTS          = 16;
    localparam int ONE            = 65536;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASES         = 13;
    localparam int MAPS_PER_PHASE = 60;
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic                operation;
        logic [IDX_IN_W-1:0] index;
        logic [FIELD_W-1:0]  position;
        logic [FIELD_W-1:0]  red;
        logic [FIELD_W-1:0]  green;
        logic [FIELD_W-1:0]  blue;
        logic [FIELD_W-1:0]  sample;
    } lut_item_t;

    // block ports, all inputs known from time zero
    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic                operation      = OP_WRITE;
    logic [IDX_IN_W-1:0] point_index    = '0;
    logic [FIELD_W-1:0]  point_position = '0;
    logic [FIELD_W-1:0]  point_red      = '0;
    logic [FIELD_W-1:0]  point_green    = '0;
    logic [FIELD_W-1:0]  point_blue     = '0;
    logic [FIELD_W-1:0]  sample_value   = '0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic [OUT_W-1:0]    red_out;
    logic [OUT_W-1:0]    green_out;
    logic [OUT_W-1:0]    blue_out;
    logic                cfg_we         = 1'b0;
    logic [NCOL_W-1:0]   cfg_wdata      = '0;

    // predictor copy of the control point memory and the color count
    logic [FIELD_W-1:0]  pos_mem   [SLOTS];
    logic [FIELD_W-1:0]  red_mem   [SLOTS];
    logic [FIELD_W-1:0]  green_mem [SLOTS];
    logic [FIELD_W-1:0]  blue_mem  [SLOTS];
    logic [NCOL_W-1:0]   num_colors_cfg = 5'd2;

    color_t              expected_colors[$];
    int                  errors      = 0;
    bit                  quiet       = 1'b0;
    int unsigned         ready_hold  = 0;

    colormap_piecewise_linear_lookup #(
        .MAX_COLORS (16),
        .FRAC_BITS  (16)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .point_index    (point_index),
        .point_position (point_position),
        .point_red      (point_red),
        .point_green    (point_green),
        .point_blue     (point_blue),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // one channel: lo*(1-f) + hi*f, scaled by 255, truncated and capped
    function automatic logic [OUT_W-1:0] blend_level(logic [FIELD_W-1:0] lo_lvl,
                                                     logic [FIELD_W-1:0] hi_lvl,
                                                     longint unsigned frac);
        longint unsigned a;
        longint unsigned b;
        longint unsigned mix;
        longint unsigned scaled;
        a      = lo_lvl;
        b      = hi_lvl;
        mix    = a * (64'd65536 - frac) + b * frac;
        scaled = (mix * 64'd255) >> 32;
        return (scaled > 64'd255) ? 8'd255 : scaled[7:0];
    endfunction

    // lower-bound search, bin pick, clamped fraction and per-channel blend
    function automatic color_t predict_color(logic [FIELD_W-1:0] value);
        int unsigned     n;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        int unsigned     lft;
        int unsigned     rgt;
        longint          v;
        longint          pl;
        longint          pr;
        longint          num;
        longint          den;
        longint unsigned frac;
        color_t          c;
        n = num_colors_cfg;
        if (n < 2)
            n = 2;
        if (n > SLOTS)
            n = SLOTS;
        lo = 0;
        hi = n - 1;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (value > pos_mem[mid])
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo == 0)
        begin
            lft = 0;
            rgt = 1;
        end
        else
        begin
            lft = lo - 1;
            rgt = lo;
        end
        v   = value;
        pl  = pos_mem[lft];
        pr  = pos_mem[rgt];
        num = v - pl;
        den = pr - pl;
        if (den == 0)
            frac = 0;
        else
        begin
            // decreasing positions flip the bin around
            if (den < 0)
            begin
                den = -den;
                num = -num;
            end
            if (num <= 0)
                frac = 0;
            else if (num >= den)
                frac = ONE;
            else
                frac = (num << 16) / den;
        end
        c.red   = blend_level(red_mem[lft], red_mem[rgt], frac);
        c.green = blend_level(green_mem[lft], green_mem[rgt], frac);
        c.blue  = blend_level(blue_mem[lft], blue_mem[rgt], frac);
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("ERROR %0t ns: %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // drive one input transaction and record what it should do
    task automatic send_item(lut_item_t it);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        operation      <= it.operation;
        point_index    <= it.index;
        point_position <= it.position;
        point_red      <= it.red;
        point_green    <= it.green;
        point_blue     <= it.blue;
        sample_value   <= it.sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (it.operation == OP_WRITE)
        begin
            pos_mem[it.index]   = it.position;
            red_mem[it.index]   = it.red;
            green_mem[it.index] = it.green;
            blue_mem[it.index]  = it.blue;
        end
        else
            expected_colors.insert(expected_colors.size(), predict_color(it.sample));
    endtask

    task automatic write_point(int unsigned idx, int unsigned pos,
                               int unsigned r, int unsigned g, int unsigned b);
        lut_item_t it;
        it.operation = OP_WRITE;
        it.index     = idx[IDX_IN_W-1:0];
        it.position  = pos[FIELD_W-1:0];
        it.red       = r[FIELD_W-1:0];
        it.green     = g[FIELD_W-1:0];
        it.blue      = b[FIELD_W-1:0];
        it.sample    = FIELD_W'($urandom_range(0, ONE));
        send_item(it);
    endtask

    task automatic map_sample(int unsigned value);
        lut_item_t it;
        it.operation = OP_MAP;
        it.index     = IDX_IN_W'($urandom_range(0, SLOTS - 1));
        it.position  = FIELD_W'($urandom_range(0, ONE));
        it.red       = FIELD_W'($urandom_range(0, ONE));
        it.green     = FIELD_W'($urandom_range(0, ONE));
        it.blue      = FIELD_W'($urandom_range(0, ONE));
        it.sample    = value[FIELD_W-1:0];
        send_item(it);
    endtask

    // let every pending color come out and the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_num_colors(int unsigned count);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= count[NCOL_W-1:0];
        @(posedge clk);
        cfg_we         <= 1'b0;
        num_colors_cfg  = count[NCOL_W-1:0];
    endtask

    function automatic int unsigned random_level();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 0;
        else if (r < 3)
            return ONE;
        else
            return $urandom_range(0, ONE);
    endfunction

    // samples aimed at points, bin interiors and the ends of the range
    function automatic int unsigned pick_sample();
        int unsigned n;
        int unsigned i;
        int unsigned r;
        int unsigned p;
        n = num_colors_cfg;
        if (n < 2)
            n = 2;
        if (n > SLOTS)
            n = SLOTS;
        i = $urandom_range(0, n - 2);
        r = $urandom_range(0, 9);
        p = pos_mem[i];
        case (r)
            0, 1, 2: return $urandom_range(0, ONE);
            3:       return pos_mem[$urandom_range(0, n - 1)];
            4:       return (p < ONE) ? p + 1 : p;
            5:       return (p > 0) ? p - 1 : p;
            6:       return $urandom_range(0, 1) ? ONE : 0;
            default: return $urandom_range(pos_mem[i], pos_mem[i + 1]);
        endcase
    endfunction

    // new table over all slots, or a few scattered rewrites
    task automatic fill_table(bit partial);
        int unsigned vals[SLOTS];
        int unsigned tmp;
        int unsigned kind;
        int unsigned count;
        int          i;
        int          j;
        if (partial)
        begin
            count = $urandom_range(1, 4);
            for (i = 0; i < count; i++)
                write_point($urandom_range(0, SLOTS - 1), $urandom_range(0, ONE),
                            random_level(), random_level(), random_level());
        end
        else
        begin
            for (i = 0; i < SLOTS; i++)
                vals[i] = $urandom_range(0, ONE);
            for (i = 1; i < SLOTS; i++)
            begin
                tmp = vals[i];
                j   = i - 1;
                while (j >= 0 && vals[j] > tmp)
                begin
                    vals[j + 1] = vals[j];
                    j--;
                end
                vals[j + 1] = tmp;
            end
            kind = $urandom_range(0, 5);
            case (kind)
                // pinned ends of the unit range
                1:
                begin
                    vals[0]         = 0;
                    vals[SLOTS - 1] = ONE;
                end
                // repeated positions give zero-width bins
                2, 3:
                begin
                    for (i = 0; i < 3; i++)
                    begin
                        j       = $urandom_range(1, SLOTS - 1);
                        vals[j] = vals[j - 1];
                    end
                end
                // two points swapped out of order
                4:
                begin
                    j           = $urandom_range(1, 5);
                    tmp         = vals[j];
                    vals[j]     = vals[j + 4];
                    vals[j + 4] = tmp;
                end
                default: ;
            endcase
            for (i = 0; i < SLOTS; i++)
                write_point(i, vals[i], random_level(), random_level(), random_level());
        end
    endtask

    // two points at the ends, full ramps both ways
    task automatic test_two_point_ramp();
        write_point(0, 0, 0, ONE, 0);
        write_point(1, ONE, ONE, 0, ONE);
        map_sample(0);
        map_sample(ONE);
        map_sample(ONE / 2);
        map_sample(1);
        map_sample(ONE - 1);
    endtask

    // samples below the first and above the last point, and one at the first
    task automatic test_out_of_span();
        write_point(0, 16384, 0, ONE, 0);
        write_point(1, 49152, ONE, 0, ONE);
        map_sample(0);
        map_sample(ONE);
        map_sample(16384);
    endtask

    task automatic test_zero_width_bin();
        write_point(1, 16384, ONE, ONE, 0);
        map_sample(16384);
        map_sample(0);
        map_sample(ONE);
    endtask

    task automatic test_decreasing_positions();
        write_point(0, 50000, ONE, 0, 32768);
        write_point(1, 10000, 0, ONE, 12345);
        map_sample(30000);
        map_sample(5000);
        map_sample(60000);
    endtask

    // phases of random tables and samples over a sweep of color counts
    task automatic test_random_tables();
        int          ph;
        int          k;
        int unsigned count;
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       count = 16;
                1:       count = 2;
                2:       count = 0;
                3:       count = 1;
                4:       count = 31;
                5:       count = 17;
                6:       count = 3;
                7:       count = 15;
                default: count = $urandom_range(0, 31);
            endcase
            set_num_colors(count);
            quiet = ($urandom_range(0, 3) == 0);
            fill_table((ph != 0) && ($urandom_range(0, 9) < 3));
            for (k = 0; k < MAPS_PER_PHASE; k++)
                map_sample(pick_sample());
        end
        quiet = 1'b0;
    endtask

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 99) < 25)
        begin
            ready_hold <= pick_gap();
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // compare each output transaction against the oldest predicted color
    always @(posedge clk)
    begin : check_colors
        color_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_colors.size() == 0)
                report_mismatch("color with no map pending", red_out, 0);
            else
            begin
                want = expected_colors.pop_front();
                if (red_out !== want.red)
                    report_mismatch("red_out", red_out, want.red);
                if (green_out !== want.green)
                    report_mismatch("green_out", green_out, want.green);
                if (blue_out !== want.blue)
                    report_mismatch("blue_out", blue_out, want.blue);
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_two_point_ramp();
        test_out_of_span();
        test_zero_width_bin();
        test_decreasing_positions();
        test_random_tables();
        drain();
        if (errors == 0)
            $display("colormap_piecewise_linear_lookup verification clean");
        else
            $display("colormap_piecewise_linear_lookup verification failed");
        $finish;
    end

    // run time limit
    initial
    begin
        #10_000_000;
        $display("colormap_piecewise_linear_lookup verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/cplut_pkg.sv
design/cplut_ram.sv
design/colormap_piecewise_linear_lookup.sv
dv/tb_colormap_piecewise_linear_lookup.sv
